[rtl/rbt_pkg.sv]
// Shared types and constants of the red-black tree table.
// Used by the controller, the datapath and the top level; depends on nothing.
`default_nettype none

package rbt_pkg;

    localparam int KEY_W      = 32;
    localparam int COUNT_W    = 7;
    localparam int OP_W       = 2;
    localparam int M_TDATA_W  = 112;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT = 2'd0,
        OP_SEARCH = 2'd1,
        OP_DUMP   = 2'd2
    } op_t;

    typedef enum logic [5:0] {
        ST_IDLE,
        ST_INS,
        ST_DESC,
        ST_DESC_W,
        ST_LINK,
        ST_F0,
        ST_F1,
        ST_F2,
        ST_F3,
        ST_F4,
        ST_C1A,
        ST_C1B,
        ST_C1C,
        ST_C3A,
        ST_C3B,
        ST_R0,
        ST_R1,
        ST_R2,
        ST_R3,
        ST_R4,
        ST_R5,
        ST_FIN,
        ST_EMIT_F,
        ST_SCAN,
        ST_SCAN_W,
        ST_DUMP0,
        ST_DL,
        ST_DLW,
        ST_DP,
        ST_DK,
        ST_EMIT_D
    } state_t;

    typedef struct packed {
        state_t step;
        logic   accept;
        logic   emit;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
        logic cur_null;
        logic link_null;
        logic red_bit;
        logic u_red;
        logic z_side;
        logic y_null;
        logic scan_done;
        logic dump_last;
        logic out_free;
    } stat_t;

endpackage

`default_nettype wire

[rtl/rbt_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// Used for every node field and for the in-order walk stack; no dependencies.
`default_nettype none

module rbt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

[rtl/rbt_ctrl.sv]
// Controller state machine: sequences insert, fix-up rotations, search and dump.
// Depends on rbt_pkg; drives the datapath through cmd_t and reads stat_t.
`default_nettype none

module rbt_ctrl (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    s_tvalid,
    input  wire logic [rbt_pkg::OP_W-1:0] operation,
    input  wire rbt_pkg::stat_t          st,
    output logic                         s_tready,
    output rbt_pkg::cmd_t                cmd
);

    rbt_pkg::state_t state_reg, state_next;
    // Set while the first rotation of the zig-zag case runs.
    logic zig_reg, zig_next;
    rbt_pkg::state_t rot_ret;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= rbt_pkg::ST_IDLE;
            zig_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            zig_reg   <= zig_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        zig_next   = zig_reg;
        s_tready   = 1'b0;
        cmd.step   = state_reg;
        cmd.accept = 1'b0;
        cmd.emit   = 1'b0;
        rot_ret    = zig_reg ? rbt_pkg::ST_C3A : rbt_pkg::ST_F0;
        case (state_reg)
            rbt_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.accept = 1'b1;
                    case (operation)
                        rbt_pkg::OP_INSERT: state_next = rbt_pkg::ST_INS;
                        rbt_pkg::OP_SEARCH: state_next = rbt_pkg::ST_SCAN;
                        rbt_pkg::OP_DUMP:   state_next = rbt_pkg::ST_DUMP0;
                        default:            state_next = rbt_pkg::ST_IDLE;
                    endcase
                end
            end
            rbt_pkg::ST_INS:
                state_next = st.full ? rbt_pkg::ST_EMIT_F : rbt_pkg::ST_DESC;
            rbt_pkg::ST_DESC:
                state_next = st.cur_null ? rbt_pkg::ST_LINK : rbt_pkg::ST_DESC_W;
            rbt_pkg::ST_DESC_W: state_next = rbt_pkg::ST_DESC;
            rbt_pkg::ST_LINK:   state_next = rbt_pkg::ST_F0;
            rbt_pkg::ST_F0:     state_next = rbt_pkg::ST_F1;
            rbt_pkg::ST_F1:
                state_next = st.link_null ? rbt_pkg::ST_FIN : rbt_pkg::ST_F2;
            rbt_pkg::ST_F2:
                state_next = (!st.red_bit || st.link_null) ? rbt_pkg::ST_FIN
                                                           : rbt_pkg::ST_F3;
            rbt_pkg::ST_F3: state_next = rbt_pkg::ST_F4;
            rbt_pkg::ST_F4: begin
                if (st.u_red) begin
                    state_next = rbt_pkg::ST_C1A;
                end else if (st.z_side) begin
                    zig_next   = 1'b1;
                    state_next = rbt_pkg::ST_R0;
                end else begin
                    state_next = rbt_pkg::ST_C3A;
                end
            end
            rbt_pkg::ST_C1A: state_next = rbt_pkg::ST_C1B;
            rbt_pkg::ST_C1B: state_next = rbt_pkg::ST_C1C;
            rbt_pkg::ST_C1C: state_next = rbt_pkg::ST_F0;
            rbt_pkg::ST_C3A: state_next = rbt_pkg::ST_C3B;
            rbt_pkg::ST_C3B: begin
                zig_next   = 1'b0;
                state_next = rbt_pkg::ST_R0;
            end
            rbt_pkg::ST_R0: state_next = rbt_pkg::ST_R1;
            rbt_pkg::ST_R1: state_next = st.y_null ? rot_ret : rbt_pkg::ST_R2;
            rbt_pkg::ST_R2: state_next = rbt_pkg::ST_R3;
            rbt_pkg::ST_R3: state_next = rbt_pkg::ST_R4;
            rbt_pkg::ST_R4: state_next = rbt_pkg::ST_R5;
            rbt_pkg::ST_R5: state_next = rot_ret;
            rbt_pkg::ST_FIN: state_next = rbt_pkg::ST_EMIT_F;
            rbt_pkg::ST_EMIT_F: begin
                if (st.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = rbt_pkg::ST_IDLE;
                end
            end
            rbt_pkg::ST_SCAN:
                state_next = st.scan_done ? rbt_pkg::ST_EMIT_F : rbt_pkg::ST_SCAN_W;
            rbt_pkg::ST_SCAN_W: state_next = rbt_pkg::ST_SCAN;
            rbt_pkg::ST_DUMP0:
                state_next = st.empty ? rbt_pkg::ST_EMIT_F : rbt_pkg::ST_DL;
            rbt_pkg::ST_DL:
                state_next = st.cur_null ? rbt_pkg::ST_DP : rbt_pkg::ST_DLW;
            rbt_pkg::ST_DLW: state_next = rbt_pkg::ST_DL;
            rbt_pkg::ST_DP:  state_next = rbt_pkg::ST_DK;
            rbt_pkg::ST_DK:  state_next = rbt_pkg::ST_EMIT_D;
            rbt_pkg::ST_EMIT_D: begin
                if (st.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = st.dump_last ? rbt_pkg::ST_IDLE : rbt_pkg::ST_DL;
                end
            end
            default: state_next = rbt_pkg::ST_IDLE;
        endcase
    end

endmodule

`default_nettype wire

[rtl/rbt_datapath.sv]
// Datapath: node table RAMs, walk stack, tree registers and the result register.
// Depends on rbt_pkg and rbt_ram; steered step by step by rbt_ctrl.
`default_nettype none

module rbt_datapath #(
    parameter int CAPACITY = 32
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire rbt_pkg::cmd_t                  cmd,
    input  wire logic [rbt_pkg::KEY_W-1:0]      key_in,
    input  wire logic                           m_tready,
    output rbt_pkg::stat_t                      st,
    output logic                                m_tvalid,
    output logic [rbt_pkg::M_TDATA_W-1:0]       m_tdata,
    output logic                                m_tuser,
    output logic                                m_tlast
);

    localparam int IDX_W  = $clog2(CAPACITY);
    localparam int LINK_W = IDX_W + 1;
    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int KW     = rbt_pkg::KEY_W;

    // A link with its top bit set is the null link.
    localparam logic [LINK_W-1:0] NIL = {1'b1, {IDX_W{1'b0}}};

    logic signed [KW-1:0] key_reg, min_reg, max_reg, dkey_reg;
    logic [LINK_W-1:0] z_reg, cur_reg, prev_reg, p_reg, g_reg, u_reg;
    logic [LINK_W-1:0] x_reg, y_reg, px_reg, c_reg, root_reg;
    logic go_right_reg, pl_reg, rdir_reg;
    logic [CNT_W-1:0] count_reg, scan_reg, n_reg, sp_reg;
    logic hit_reg, drop_reg, dval_reg, dlast_reg;
    logic out_valid_reg, out_user_reg, out_last_reg;
    logic [rbt_pkg::M_TDATA_W-1:0] out_data_reg;

    // RAM ports.
    logic [KW-1:0]     rd_key, key_wd;
    logic [LINK_W-1:0] rd_left, rd_right, rd_parent, rd_stack;
    logic [LINK_W-1:0] left_wd, right_wd, parent_wd, stack_wd;
    logic              rd_red, red_wd;
    logic key_we, left_we, right_we, parent_we, red_we, stack_we;
    logic [IDX_W-1:0] key_wa, left_wa, right_wa, parent_wa, red_wa, stack_wa;
    logic [IDX_W-1:0] key_ra, left_ra, right_ra, parent_ra, red_ra, stack_ra;

    logic [LINK_W-1:0] y_sel, u_sel, z_link;
    logic [CNT_W-1:0]  sp_dec;
    logic              out_free;
    logic signed [KW-1:0] min_out, max_out;

    assign y_sel    = rdir_reg ? rd_right : rd_left;
    assign u_sel    = (p_reg == rd_left) ? rd_right : rd_left;
    assign z_link   = LINK_W'(count_reg);
    assign sp_dec   = sp_reg - CNT_W'(1);
    assign out_free = !out_valid_reg || m_tready;
    assign min_out  = (count_reg == '0) ? '1 : min_reg;
    assign max_out  = (count_reg == '0) ? '1 : max_reg;

    assign st.full      = (count_reg == CNT_W'(CAPACITY));
    assign st.empty     = (count_reg == '0);
    assign st.cur_null  = cur_reg[IDX_W];
    assign st.link_null = rd_parent[IDX_W];
    assign st.red_bit   = rd_red;
    assign st.u_red     = !u_reg[IDX_W] && rd_red;
    assign st.z_side    = pl_reg ? (z_reg == rd_right) : (z_reg == rd_left);
    assign st.y_null    = y_sel[IDX_W];
    assign st.scan_done = (scan_reg == count_reg);
    assign st.dump_last = dlast_reg;
    assign st.out_free  = out_free;

    always_comb begin
        key_we = 1'b0;   key_wa = '0;    key_wd = key_reg;
        left_we = 1'b0;  left_wa = '0;   left_wd = NIL;
        right_we = 1'b0; right_wa = '0;  right_wd = NIL;
        parent_we = 1'b0; parent_wa = '0; parent_wd = NIL;
        red_we = 1'b0;   red_wa = '0;    red_wd = 1'b0;
        stack_we = 1'b0; stack_wa = sp_reg[IDX_W-1:0]; stack_wd = cur_reg;
        key_ra = cur_reg[IDX_W-1:0];
        left_ra = cur_reg[IDX_W-1:0];
        right_ra = cur_reg[IDX_W-1:0];
        parent_ra = z_reg[IDX_W-1:0];
        red_ra = rd_parent[IDX_W-1:0];
        stack_ra = sp_dec[IDX_W-1:0];
        case (cmd.step)
            rbt_pkg::ST_INS: begin
                key_we = !st.full;   key_wa = z_link[IDX_W-1:0];
                left_we = !st.full;  left_wa = z_link[IDX_W-1:0];
                right_we = !st.full; right_wa = z_link[IDX_W-1:0];
                red_we = !st.full;   red_wa = z_link[IDX_W-1:0]; red_wd = 1'b1;
            end
            rbt_pkg::ST_LINK: begin
                parent_we = 1'b1; parent_wa = z_reg[IDX_W-1:0]; parent_wd = prev_reg;
                left_wa = prev_reg[IDX_W-1:0];  left_wd = z_reg;
                right_wa = prev_reg[IDX_W-1:0]; right_wd = z_reg;
                left_we = !prev_reg[IDX_W] && !go_right_reg;
                right_we = !prev_reg[IDX_W] && go_right_reg;
            end
            rbt_pkg::ST_F1: begin
                // Fetch the grandparent while the parent's color is read.
                parent_ra = rd_parent[IDX_W-1:0];
            end
            rbt_pkg::ST_F2: begin
                left_ra = rd_parent[IDX_W-1:0];
                right_ra = rd_parent[IDX_W-1:0];
            end
            rbt_pkg::ST_F3: begin
                left_ra = p_reg[IDX_W-1:0];
                right_ra = p_reg[IDX_W-1:0];
                red_ra = u_sel[IDX_W-1:0];
            end
            rbt_pkg::ST_C1A: begin
                red_we = 1'b1; red_wa = p_reg[IDX_W-1:0];
            end
            rbt_pkg::ST_C1B: begin
                red_we = 1'b1; red_wa = u_reg[IDX_W-1:0];
            end
            rbt_pkg::ST_C1C: begin
                red_we = 1'b1; red_wa = g_reg[IDX_W-1:0]; red_wd = 1'b1;
            end
            rbt_pkg::ST_C3A: begin
                red_we = 1'b1; red_wa = p_reg[IDX_W-1:0];
            end
            rbt_pkg::ST_C3B: begin
                red_we = 1'b1; red_wa = g_reg[IDX_W-1:0]; red_wd = 1'b1;
            end
            rbt_pkg::ST_R0: begin
                left_ra = x_reg[IDX_W-1:0];
                right_ra = x_reg[IDX_W-1:0];
                parent_ra = x_reg[IDX_W-1:0];
            end
            rbt_pkg::ST_R1: begin
                left_ra = y_sel[IDX_W-1:0];
                right_ra = y_sel[IDX_W-1:0];
            end
            rbt_pkg::ST_R2: begin
                // The inner child of y moves across to x.
                left_wa = x_reg[IDX_W-1:0];  left_wd = rd_right;
                right_wa = x_reg[IDX_W-1:0]; right_wd = rd_left;
                left_we = !rdir_reg;
                right_we = rdir_reg;
                left_ra = px_reg[IDX_W-1:0];
            end
            rbt_pkg::ST_R3: begin
                parent_we = 1'b1; parent_wa = y_reg[IDX_W-1:0]; parent_wd = px_reg;
                left_wa = px_reg[IDX_W-1:0];  left_wd = y_reg;
                right_wa = px_reg[IDX_W-1:0]; right_wd = y_reg;
                left_we = !px_reg[IDX_W] && (rd_left == x_reg);
                right_we = !px_reg[IDX_W] && (rd_left != x_reg);
            end
            rbt_pkg::ST_R4: begin
                parent_we = !c_reg[IDX_W]; parent_wa = c_reg[IDX_W-1:0];
                parent_wd = x_reg;
                left_wa = y_reg[IDX_W-1:0];  left_wd = x_reg;
                right_wa = y_reg[IDX_W-1:0]; right_wd = x_reg;
                left_we = rdir_reg;
                right_we = !rdir_reg;
            end
            rbt_pkg::ST_R5: begin
                parent_we = 1'b1; parent_wa = x_reg[IDX_W-1:0]; parent_wd = y_reg;
            end
            rbt_pkg::ST_FIN: begin
                red_we = !root_reg[IDX_W]; red_wa = root_reg[IDX_W-1:0];
            end
            rbt_pkg::ST_SCAN: begin
                key_ra = scan_reg[IDX_W-1:0];
            end
            rbt_pkg::ST_DL: begin
                stack_we = !cur_reg[IDX_W];
            end
            rbt_pkg::ST_DP: begin
                key_ra = rd_stack[IDX_W-1:0];
                right_ra = rd_stack[IDX_W-1:0];
            end
            default: ;
        endcase
    end

    rbt_ram #(.WIDTH(KW), .DEPTH(CAPACITY)) u_key_ram (
        .aclk(aclk), .we(key_we), .waddr(key_wa), .wdata(key_wd),
        .raddr(key_ra), .rdata(rd_key)
    );
    rbt_ram #(.WIDTH(LINK_W), .DEPTH(CAPACITY)) u_left_ram (
        .aclk(aclk), .we(left_we), .waddr(left_wa), .wdata(left_wd),
        .raddr(left_ra), .rdata(rd_left)
    );
    rbt_ram #(.WIDTH(LINK_W), .DEPTH(CAPACITY)) u_right_ram (
        .aclk(aclk), .we(right_we), .waddr(right_wa), .wdata(right_wd),
        .raddr(right_ra), .rdata(rd_right)
    );
    rbt_ram #(.WIDTH(LINK_W), .DEPTH(CAPACITY)) u_parent_ram (
        .aclk(aclk), .we(parent_we), .waddr(parent_wa), .wdata(parent_wd),
        .raddr(parent_ra), .rdata(rd_parent)
    );
    rbt_ram #(.WIDTH(1), .DEPTH(CAPACITY)) u_red_ram (
        .aclk(aclk), .we(red_we), .waddr(red_wa), .wdata(red_wd),
        .raddr(red_ra), .rdata(rd_red)
    );
    rbt_ram #(.WIDTH(LINK_W), .DEPTH(CAPACITY)) u_stack_ram (
        .aclk(aclk), .we(stack_we), .waddr(stack_wa), .wdata(stack_wd),
        .raddr(stack_ra), .rdata(rd_stack)
    );

    // Control state: tree root, node count and the result handshake.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            root_reg      <= NIL;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cmd.emit) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
            if (cmd.step == rbt_pkg::ST_INS && !st.full) begin
                count_reg <= count_reg + CNT_W'(1);
            end
            if (cmd.step == rbt_pkg::ST_LINK && prev_reg[IDX_W]) begin
                root_reg <= z_reg;
            end
            if (cmd.step == rbt_pkg::ST_R3 && px_reg[IDX_W]) begin
                root_reg <= y_reg;
            end
        end
    end

    // Working registers of the current operation.
    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            key_reg   <= $signed(key_in);
            cur_reg   <= root_reg;
            prev_reg  <= NIL;
            scan_reg  <= '0;
            sp_reg    <= '0;
            n_reg     <= '0;
            hit_reg   <= 1'b0;
            drop_reg  <= 1'b0;
            dval_reg  <= 1'b0;
            dkey_reg  <= '0;
            dlast_reg <= 1'b1;
        end
        case (cmd.step)
            rbt_pkg::ST_INS: begin
                if (st.full) begin
                    drop_reg <= 1'b1;
                end else begin
                    z_reg <= z_link;
                    if (count_reg == '0 || key_reg < min_reg) min_reg <= key_reg;
                    if (count_reg == '0 || key_reg > max_reg) max_reg <= key_reg;
                end
            end
            rbt_pkg::ST_DESC_W: begin
                // Equal keys descend to the left.
                go_right_reg <= $signed(rd_key) < key_reg;
                prev_reg     <= cur_reg;
                cur_reg      <= ($signed(rd_key) < key_reg) ? rd_right : rd_left;
            end
            rbt_pkg::ST_F1: p_reg <= rd_parent;
            rbt_pkg::ST_F2: g_reg <= rd_parent;
            rbt_pkg::ST_F3: begin
                pl_reg <= (p_reg == rd_left);
                u_reg  <= u_sel;
            end
            rbt_pkg::ST_F4: begin
                if (!st.u_red && st.z_side) begin
                    z_reg    <= p_reg;
                    p_reg    <= z_reg;
                    x_reg    <= p_reg;
                    rdir_reg <= pl_reg;
                end
            end
            rbt_pkg::ST_C1C: z_reg <= g_reg;
            rbt_pkg::ST_C3B: begin
                x_reg    <= g_reg;
                rdir_reg <= !pl_reg;
            end
            rbt_pkg::ST_R1: begin
                y_reg  <= y_sel;
                px_reg <= rd_parent;
            end
            rbt_pkg::ST_R2: c_reg <= rdir_reg ? rd_left : rd_right;
            rbt_pkg::ST_SCAN: scan_reg <= scan_reg + CNT_W'(1);
            rbt_pkg::ST_SCAN_W: begin
                if ($signed(rd_key) == key_reg) hit_reg <= 1'b1;
            end
            rbt_pkg::ST_DL: begin
                if (cur_reg[IDX_W]) begin
                    sp_reg <= sp_dec;
                end else begin
                    sp_reg <= sp_reg + CNT_W'(1);
                end
            end
            rbt_pkg::ST_DLW: cur_reg <= rd_left;
            rbt_pkg::ST_DK: begin
                dkey_reg  <= $signed(rd_key);
                cur_reg   <= rd_right;
                dval_reg  <= 1'b1;
                dlast_reg <= (n_reg + CNT_W'(1) == count_reg);
                n_reg     <= n_reg + CNT_W'(1);
            end
            default: ;
        endcase
        if (cmd.emit) begin
            out_data_reg <= {7'b0, rbt_pkg::COUNT_W'(count_reg), max_out, min_out,
                             dkey_reg, drop_reg, hit_reg};
            out_user_reg <= dval_reg;
            out_last_reg <= dlast_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;
    assign m_tlast  = out_last_reg;

endmodule

`default_nettype wire

[rtl/red_black_tree_table.sv]
// Red-black tree table of signed 32-bit keys, top level.
// Depends on rbt_pkg, rbt_ctrl, rbt_datapath and rbt_ram.
//
// Input channel (s_): tuser carries the operation (insert, search, dump),
// tdata the key. Result channel (m_): tdata carries found, dropped, key_out,
// minimum, maximum and count; tuser flags a dump key; tlast ends the results
// of one input transaction. Insert and search give one result; a dump gives one
// result per stored key in ascending order, or one empty result.
// One item is worked on at a time; s_tready is high only when idle, even while
// the last result waits in the output register.
// Insert descends level by level through the registered node RAM reads, then
// recolors level by level or does a single or a double rotation as needed,
// and finishes by blackening the root; a dropped insert skips to its result.
// Search scans the live nodes in turn, comparing each key.
// Dump walks the tree in order through the stack and node RAM reads.
// Reset empties the tree at once; node RAMs are not cleared.
// When the receiver stalls, the block holds its result; a later operation runs
// on and waits in its emit state until the output register is free.
`default_nettype none

module red_black_tree_table #(
    parameter int CAPACITY = 32
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_tvalid,
    output logic               s_tready,
    input  wire logic [31:0]   s_tdata,   // key
    input  wire logic [1:0]    s_tuser,   // operation
    output logic               m_tvalid,
    input  wire logic          m_tready,
    // found, dropped, key_out, minimum, maximum, count, zero pad
    output logic [111:0]       m_tdata,
    output logic               m_tuser,   // item_valid
    output logic               m_tlast
);

    rbt_pkg::cmd_t  cmd;
    rbt_pkg::stat_t st;

    rbt_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .operation (s_tuser),
        .st        (st),
        .s_tready  (s_tready),
        .cmd       (cmd)
    );

    rbt_datapath #(.CAPACITY(CAPACITY)) u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .key_in   (s_tdata),
        .m_tready (m_tready),
        .st       (st),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

`default_nettype wire

[rtl/rbt_checker.sv]
// Port-level checker for the red-black tree table, bound to the top level.
// Depends only on the top level's ports.
`default_nettype none

module rbt_checker #(
    parameter int CAPACITY = 32
) (
    input wire logic         aclk,
    input wire logic         aresetn,
    input wire logic         s_tvalid,
    input wire logic         s_tready,
    input wire logic [1:0]   s_tuser,
    input wire logic         m_tvalid,
    input wire logic         m_tready,
    input wire logic [111:0] m_tdata,
    input wire logic         m_tuser,
    input wire logic         m_tlast
);

    // A stalled result holds.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result changed while stalled");

    // A real operation keeps the block busy for at least the next cycle.
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && (s_tuser != 2'd3) |=> !s_tready)
        else $error("accepted a transaction while busy");

    // Anything but a dump key is the only result of its transaction.
    a_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tlast)
        else $error("single result without tlast");

    a_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[104:98] <= CAPACITY)
        else $error("count above capacity");

    // An empty tree reports minus one as both extremes.
    a_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[104:98] == 7'd0) |->
            (m_tdata[65:34] == 32'hFFFF_FFFF) && (m_tdata[97:66] == 32'hFFFF_FFFF))
        else $error("empty tree extremes wrong");

endmodule

bind red_black_tree_table rbt_checker #(.CAPACITY(CAPACITY)) u_rbt_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

`default_nettype wire

[sim/red_black_tree_table_tb.sv]
// Self-checking testbench for red_black_tree_table: drives insert, search and dump
// transactions and checks every result against a behavioral red-black tree model.
// Depends on rbt_pkg and the red_black_tree_table RTL.
`timescale 1ns / 1ps

module red_black_tree_table_tb;

    localparam int CAP = 32;
    localparam int NIL = 63;

    typedef struct packed {
        logic [1:0]  op;
        logic [31:0] key;
    } req_t;

    typedef struct packed {
        logic        found;
        logic        dropped;
        logic        item_valid;
        logic [31:0] key_out;
        logic        last;
        logic [31:0] minimum;
        logic [31:0] maximum;
        logic [6:0]  count;
    } rsp_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [31:0] s_tdata = '0;
    logic [1:0] s_tuser = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [111:0] m_tdata;
    logic m_tuser;
    logic m_tlast;

    req_t pending_reqs[$];
    rsp_t expected_rsps[$];
    int errors = 0;
    int rsp_seen = 0;
    int dumps_seen = 0;
    int drops_seen = 0;
    int send_idle_pct = 19;
    int recv_idle_pct = 82;
    logic done = 1'b0;
    // Set by the monitor when the input transaction was taken at the last rising edge.
    logic in_taken = 1'b0;

    // Tree model state.
    logic signed [31:0] t_key[CAP];
    int t_left[CAP], t_right[CAP], t_parent[CAP];
    bit t_red[CAP];
    int t_root = NIL;
    int t_count = 0;

    red_black_tree_table #(.CAPACITY(CAP)) u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .m_tlast(m_tlast)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    function automatic bit is_red(int i);
        return i != NIL && t_red[i];
    endfunction

    function automatic void hook_parent(int x, int y);
        int p;
        p = t_parent[x];
        t_parent[y] = p;
        if (p == NIL) t_root = y;
        else if (t_left[p] == x) t_left[p] = y;
        else t_right[p] = y;
    endfunction

    function automatic void rot_left(int x);
        int y;
        y = t_right[x];
        if (y == NIL) return;
        t_right[x] = t_left[y];
        if (t_left[y] != NIL) t_parent[t_left[y]] = x;
        hook_parent(x, y);
        t_left[y] = x;
        t_parent[x] = y;
    endfunction

    function automatic void rot_right(int x);
        int y;
        y = t_left[x];
        if (y == NIL) return;
        t_left[x] = t_right[y];
        if (t_right[y] != NIL) t_parent[t_right[y]] = x;
        hook_parent(x, y);
        t_right[y] = x;
        t_parent[x] = y;
    endfunction

    function automatic bit tree_insert(logic signed [31:0] k);
        int z, cur, prev, p, g, u;
        bit go_right;
        prev = NIL;
        go_right = 0;
        if (t_count >= CAP) return 0;
        z = t_count;
        t_count++;
        t_key[z] = k;
        t_left[z] = NIL;
        t_right[z] = NIL;
        t_red[z] = 1;
        cur = t_root;
        while (cur != NIL) begin
            prev = cur;
            go_right = t_key[cur] < k;
            cur = go_right ? t_right[cur] : t_left[cur];
        end
        t_parent[z] = prev;
        if (prev == NIL) t_root = z;
        else if (go_right) t_right[prev] = z;
        else t_left[prev] = z;
        // Recolor and rotate until the parent is black, is the root or is missing.
        while (t_parent[z] != NIL && t_red[t_parent[z]]) begin
            p = t_parent[z];
            g = t_parent[p];
            if (g == NIL) break;
            if (p == t_left[g]) begin
                u = t_right[g];
                if (is_red(u)) begin
                    t_red[p] = 0; t_red[u] = 0; t_red[g] = 1; z = g;
                end else begin
                    if (z == t_right[p]) begin
                        z = p; rot_left(z); p = t_parent[z];
                    end
                    t_red[p] = 0; t_red[g] = 1; rot_right(g);
                end
            end else begin
                u = t_left[g];
                if (is_red(u)) begin
                    t_red[p] = 0; t_red[u] = 0; t_red[g] = 1; z = g;
                end else begin
                    if (z == t_left[p]) begin
                        z = p; rot_right(z); p = t_parent[z];
                    end
                    t_red[p] = 0; t_red[g] = 1; rot_left(g);
                end
            end
        end
        if (t_root != NIL) t_red[t_root] = 0;
        return 1;
    endfunction

    function automatic logic [31:0] tree_extreme(bit want_max);
        int cur;
        cur = t_root;
        if (cur == NIL) return 32'hFFFF_FFFF;
        while ((want_max ? t_right[cur] : t_left[cur]) != NIL)
            cur = want_max ? t_right[cur] : t_left[cur];
        return t_key[cur];
    endfunction

    function automatic void push_result(bit f, bit d, bit v, logic [31:0] k, bit l);
        rsp_t r;
        r.found = f; r.dropped = d; r.item_valid = v; r.key_out = k; r.last = l;
        r.minimum = tree_extreme(0);
        r.maximum = tree_extreme(1);
        r.count = t_count[6:0];
        expected_rsps.push_back(r);
    endfunction

    // Works out the results of one accepted transaction.
    function automatic void predict_table(req_t q);
        bit ok, hit;
        int stk[$];
        int cur, n;
        case (q.op)
            rbt_pkg::OP_INSERT: begin
                ok = tree_insert(q.key);
                push_result(0, !ok, 0, '0, 1);
            end
            rbt_pkg::OP_SEARCH: begin
                hit = 0;
                for (int i = 0; i < t_count; i++)
                    if (t_key[i] == q.key) hit = 1;
                push_result(hit, 0, 0, '0, 1);
            end
            rbt_pkg::OP_DUMP: begin
                if (t_count == 0) push_result(0, 0, 0, '0, 1);
                else begin
                    cur = t_root;
                    n = 0;
                    while (cur != NIL || stk.size() > 0) begin
                        while (cur != NIL) begin
                            stk.push_back(cur);
                            cur = t_left[cur];
                        end
                        cur = stk.pop_back();
                        n++;
                        push_result(0, 0, 1, t_key[cur], n == t_count);
                        cur = t_right[cur];
                    end
                end
            end
            default: ;
        endcase
    endfunction

    // Driver: inputs change on the falling edge.
    always @(negedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && !in_taken) begin
                // hold the current transaction
            end else if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                s_tvalid <= 1'b1;
                s_tuser <= pending_reqs[0].op;
                s_tdata <= pending_reqs[0].key;
                pending_reqs.pop_front();
            end else begin
                s_tvalid <= 1'b0;
            end
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Monitor: predicts on input acceptance, checks on output acceptance.
    always @(posedge aclk) begin
        rsp_t got, want;
        req_t q;
        in_taken = aresetn && s_tvalid && s_tready;
        if (aresetn && s_tvalid && s_tready) begin
            q.op = s_tuser;
            q.key = s_tdata;
            predict_table(q);
        end
        if (aresetn && m_tvalid && m_tready) begin
            got.found = m_tdata[0];
            got.dropped = m_tdata[1];
            got.key_out = m_tdata[33:2];
            got.minimum = m_tdata[65:34];
            got.maximum = m_tdata[97:66];
            got.count = m_tdata[104:98];
            got.item_valid = m_tuser;
            got.last = m_tlast;
            rsp_seen++;
            if (got.item_valid) dumps_seen++;
            if (got.dropped) drops_seen++;
            if (expected_rsps.size() == 0) begin
                errors++;
                $display("%0t: unexpected result %h", $time, got);
            end else begin
                want = expected_rsps.pop_front();
                if (got !== want) begin
                    errors++;
                    $display("%0t: mismatch expected %h actual %h", $time, want, got);
                end
            end
        end
    end

    function automatic logic [31:0] pick_key(int pool);
        case ($urandom_range(9))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'hFFFF_FFFF;
            3, 4: return $urandom;
            default: return $urandom_range(pool) - pool / 2;
        endcase
    endfunction

    task automatic queue_req(logic [1:0] op, logic [31:0] key);
        req_t q;
        q.op = op;
        q.key = key;
        pending_reqs.push_back(q);
    endtask

    task automatic drain();
        int guard;
        guard = 0;
        while ((pending_reqs.size() > 0 || s_tvalid || expected_rsps.size() > 0)
               && guard < 400000) begin
            @(posedge aclk);
            guard++;
        end
    endtask

    initial begin
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed: empty dump and search, unused selector, extremes, duplicates.
        queue_req(rbt_pkg::OP_DUMP, '0);
        queue_req(rbt_pkg::OP_SEARCH, 32'hFFFF_FFFF);
        queue_req(2'd3, 32'h1234_5678);
        queue_req(rbt_pkg::OP_INSERT, 32'h8000_0000);
        queue_req(rbt_pkg::OP_INSERT, 32'h7FFF_FFFF);
        queue_req(rbt_pkg::OP_INSERT, 32'hFFFF_FFFF);
        queue_req(rbt_pkg::OP_INSERT, 32'h0000_0000);
        queue_req(rbt_pkg::OP_INSERT, 32'hFFFF_FFFF);
        queue_req(rbt_pkg::OP_SEARCH, 32'hFFFF_FFFF);
        queue_req(rbt_pkg::OP_SEARCH, 32'h8000_0000);
        queue_req(rbt_pkg::OP_SEARCH, 32'h5555_AAAA);
        queue_req(rbt_pkg::OP_DUMP, 32'hFFFF_FFFF);

        // Random phases; the table fills in the first one, so later inserts are dropped.
        for (int phase = 0; phase < 3; phase++) begin
            if (phase == 1) begin
                send_idle_pct = 82;
                recv_idle_pct = 19;
            end else if (phase == 2) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            for (int i = 0; i < 116; i++) begin
                case ($urandom_range(9))
                    0, 1, 2, 3, 4: queue_req(rbt_pkg::OP_INSERT, pick_key(64));
                    5, 6, 7: queue_req(rbt_pkg::OP_SEARCH, pick_key(64));
                    8: queue_req(rbt_pkg::OP_DUMP, $urandom);
                    default: queue_req(2'd3, $urandom);
                endcase
            end
            queue_req(rbt_pkg::OP_DUMP, '0);
            drain();
        end
        repeat (200) @(posedge aclk);
        done = 1'b1;
        $display("Checked %0d results, %0d dump keys and %0d dropped inserts.",
                 rsp_seen, dumps_seen, drops_seen);
        if (errors == 0 && expected_rsps.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    initial begin
        #3000000;
        if (!done) begin
            $display("tb: failure");
            $finish;
        end
    end

endmodule
